[src/lsps_pkg.sv]
// Shared types, constants and the pattern ROM for the LED status pattern sequencer.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package lsps_pkg;

  localparam int unsigned ROM_DW      = 12;   // width of on/off times held in the ROM
  localparam int unsigned CHAIN_LIMIT = 64;   // bound on steps walked for one transfer
  localparam int unsigned GUARD_W     = $clog2(CHAIN_LIMIT);

  typedef logic [ROM_DW-1:0] rom_delay_t;

  localparam rom_delay_t HOLD_RECHECK = 12'd1000;

  localparam logic [3:0] STATUS_OTA_OK = 4'd6;
  localparam logic [3:0] STATUS_OFF    = 4'd8;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_STOP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_ACTIVE   = 2'd1,
    PH_COMPLETE = 2'd2
  } phase_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  typedef struct packed {
    rom_delay_t on_ms;
    rom_delay_t off_ms;
    logic       rpt;
    logic [1:0] flashes;
  } step_t;

  // Request to the step unit: one step of a pattern engine walk
  typedef struct packed {
    logic [3:0] status;
    logic [1:0] step_index;
    logic [1:0] flash_counter;
    logic       led_level;
    logic       start_step;
  } step_req_t;

  typedef struct packed {
    logic       done;          // walk finished with a timer load or completion
    logic       complete;      // pattern finished, LED off
    logic       load;          // timer to be loaded with delay
    rom_delay_t delay;
    logic [1:0] step_index;
    logic [1:0] flash_counter;
    logic       led_level;
    logic       start_next;
  } step_rsp_t;

  function automatic step_t mk_step(input rom_delay_t on_ms, input rom_delay_t off_ms,
                                    input logic rpt, input logic [1:0] flashes);
    step_t s;
    s.on_ms   = on_ms;
    s.off_ms  = off_ms;
    s.rpt     = rpt;
    s.flashes = flashes;
    return s;
  endfunction

  // Pattern ROM; unlisted steps and statuses hold the LED off.
  function automatic step_t rom_step(input logic [3:0] status, input logic [1:0] idx);
    step_t s;
    s = mk_step(12'd0, 12'd0, 1'b0, 2'd0);
    case ({status, idx})
      {4'd0, 2'd0}: s = mk_step(12'd2000, 12'd0,    1'b1, 2'd1);
      {4'd1, 2'd0}: s = mk_step(12'd200,  12'd800,  1'b0, 2'd1);
      {4'd2, 2'd0}: s = mk_step(12'd2000, 12'd0,    1'b1, 2'd1);
      {4'd3, 2'd0}: s = mk_step(12'd200,  12'd200,  1'b1, 2'd2);
      {4'd3, 2'd1}: s = mk_step(12'd0,    12'd600,  1'b1, 2'd1);
      {4'd3, 2'd2}: s = mk_step(12'd200,  12'd200,  1'b0, 2'd2);
      {4'd4, 2'd0}: s = mk_step(12'd2000, 12'd0,    1'b1, 2'd1);
      {4'd5, 2'd0}: s = mk_step(12'd200,  12'd2800, 1'b0, 2'd1);
      {4'd7, 2'd0}: s = mk_step(12'd100,  12'd100,  1'b1, 2'd3);
      {4'd7, 2'd1}: s = mk_step(12'd0,    12'd2700, 1'b1, 2'd1);
      default:      s = mk_step(12'd0,    12'd0,    1'b0, 2'd0);
    endcase
    return s;
  endfunction

  function automatic logic [1:0] rom_count(input logic [3:0] status);
    logic [1:0] c;
    case (status)
      4'd3:    c = 2'd3;
      4'd7:    c = 2'd2;
      default: c = 2'd1;
    endcase
    return c;
  endfunction

endpackage

[src/lsps_step_unit.sv]
// Step unit: one step of a pattern engine walk per cycle (step start, flash count
// check, LED toggle and delay pick). Depends on lsps_pkg.
`timescale 1ns / 1ps

module lsps_step_unit (
  input  lsps_pkg::step_req_t req,
  output lsps_pkg::step_rsp_t rsp
);
  import lsps_pkg::*;

  logic [1:0] idx;
  logic [1:0] fc;
  logic       led;
  logic       halt;
  step_t      first;
  step_t      cur;
  rom_delay_t dly;

  assign first = rom_step(req.status, 2'd0);
  assign cur   = rom_step(req.status, idx);

  always_comb begin
    idx  = req.step_index;
    fc   = req.flash_counter;
    halt = 1'b0;
    if (req.start_step) begin
      fc = 2'd0;
      if (idx >= rom_count(req.status)) begin
        if (!first.rpt) begin
          idx = 2'd0;
        end else begin
          halt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp               = '0;
    rsp.step_index    = idx;
    rsp.flash_counter = fc;
    rsp.led_level     = req.led_level;
    led               = req.led_level;
    dly               = '0;
    if (halt) begin
      rsp.done      = 1'b1;
      rsp.complete  = 1'b1;
      rsp.led_level = 1'b0;
    end else if (cur.flashes != 2'd0 && fc >= cur.flashes) begin
      rsp.step_index = idx + 2'd1;
      rsp.start_next = 1'b1;
    end else begin
      if (cur.on_ms == '0 && cur.off_ms == '0) begin
        led = 1'b0;
        dly = HOLD_RECHECK;
      end else if (!req.led_level) begin
        led = 1'b1;
        dly = cur.on_ms;
      end else begin
        led = 1'b0;
        dly = cur.off_ms;
        rsp.flash_counter = fc + 2'd1;
      end
      rsp.led_level = led;
      rsp.delay     = dly;
      // zero delay chains on to the next toggle in the following cycle
      if (dly != '0) begin
        rsp.done = 1'b1;
        rsp.load = 1'b1;
      end
    end
  end

endmodule

[src/led_status_pattern_sequencer.sv]
// Top level of the LED status pattern sequencer: handshakes, state registers,
// walk sequencer and result register. Depends on lsps_pkg and lsps_step_unit.
`timescale 1ns / 1ps

// One status LED follows a fixed blink pattern chosen by a status select; a tick
// transfer advances the 1 ms countdown and a stop switches everything off. Each
// input transfer gives exactly one result: LED level, phase, status and a reject
// flag for out-of-range selects. Ticks that do not expire the countdown, stops,
// rejected selects and the off/OTA-success selects need no walk: the result is
// registered from the transfer itself. A select that starts a pattern, or a tick
// that expires the countdown while active, walks the pattern through the shared
// step unit one step per cycle (toggles with zero delay and flash-count advances
// each take a step); its result is registered when the walk ends. The input is
// stalled while a walk runs or while an earlier result is still held.
module led_status_pattern_sequencer #(
  parameter int STATUS_COUNT = 9,
  parameter int DELAY_BITS   = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_status,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_led_on,
  output logic [1:0] out_pattern_phase,
  output logic [3:0] out_sel_status,
  output logic       out_rejected
);
  import lsps_pkg::*;

  localparam logic [16:0] DLY_MAX = 17'((1 << DELAY_BITS) - 1);

  seq_state_t              state_r, state_nxt;
  logic [3:0]              status_r, status_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [1:0]              step_idx_r, step_idx_nxt;
  logic [1:0]              flash_cnt_r, flash_cnt_nxt;
  logic                    led_r, led_nxt;
  logic [DELAY_BITS-1:0]   delay_r, delay_nxt;
  logic                    running_r, running_nxt;
  logic [GUARD_W-1:0]      guard_r, guard_nxt;
  logic                    start_r, start_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_led_r, out_led_nxt;
  logic [1:0]              out_phase_r, out_phase_nxt;
  logic [3:0]              out_status_r, out_status_nxt;
  logic                    out_rej_r, out_rej_nxt;

  logic                    in_xfer;
  logic                    go_run;
  logic                    finish;
  logic                    emit;
  logic                    rej;
  logic [16:0]             dly_wide;
  logic [16:0]             dly_sat;
  step_req_t               req;
  step_rsp_t               rsp;

  assign in_xfer = in_valid && !in_stall;

  assign req.status        = status_r;
  assign req.step_index    = step_idx_r;
  assign req.flash_counter = flash_cnt_r;
  assign req.led_level     = led_r;
  assign req.start_step    = start_r;

  lsps_step_unit u_step (
    .req (req),
    .rsp (rsp)
  );

  assign dly_wide = {{(17 - ROM_DW){1'b0}}, rsp.delay};
  assign dly_sat  = (dly_wide > DLY_MAX) ? DLY_MAX : dly_wide;

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: if (in_xfer && go_run) state_nxt = SEQ_RUN;
      SEQ_RUN:  if (finish) state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    unique case (state_r)
      SEQ_IDLE: in_stall = out_valid_r && out_stall;
      SEQ_RUN:  in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  // Datapath
  always_comb begin
    status_nxt     = status_r;
    phase_nxt      = phase_r;
    step_idx_nxt   = step_idx_r;
    flash_cnt_nxt  = flash_cnt_r;
    led_nxt        = led_r;
    delay_nxt      = delay_r;
    running_nxt    = running_r;
    guard_nxt      = guard_r;
    start_nxt      = start_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_led_nxt    = out_led_r;
    out_phase_nxt  = out_phase_r;
    out_status_nxt = out_status_r;
    out_rej_nxt    = out_rej_r;
    go_run         = 1'b0;
    finish         = 1'b0;
    emit           = 1'b0;
    rej            = 1'b0;

    if (state_r == SEQ_IDLE) begin
      if (in_xfer) begin
        unique case (in_action)
          ACT_TICK: begin
            if (running_r) begin
              if (delay_r <= DELAY_BITS'(1)) begin
                delay_nxt   = '0;
                running_nxt = 1'b0;
                if (phase_r == PH_ACTIVE) begin
                  go_run    = 1'b1;
                  start_nxt = 1'b0;
                end
              end else begin
                delay_nxt = delay_r - DELAY_BITS'(1);
              end
            end
          end
          ACT_SELECT: begin
            if ({1'b0, in_status} >= 5'(STATUS_COUNT)) begin
              rej = 1'b1;
            end else begin
              running_nxt   = 1'b0;
              delay_nxt     = '0;
              status_nxt    = in_status;
              phase_nxt     = PH_ACTIVE;
              step_idx_nxt  = 2'd0;
              flash_cnt_nxt = 2'd0;
              if (in_status == STATUS_OFF || in_status == STATUS_OTA_OK) begin
                led_nxt   = 1'b0;
                phase_nxt = PH_COMPLETE;
              end else begin
                go_run    = 1'b1;
                start_nxt = 1'b1;
              end
            end
          end
          ACT_STOP: begin
            running_nxt = 1'b0;
            delay_nxt   = '0;
            led_nxt     = 1'b0;
            phase_nxt   = PH_IDLE;
            status_nxt  = STATUS_OFF;
          end
          default: ;
        endcase
        guard_nxt = '0;
        emit      = !go_run;
      end
    end else begin
      step_idx_nxt  = rsp.step_index;
      flash_cnt_nxt = rsp.flash_counter;
      led_nxt       = rsp.led_level;
      start_nxt     = rsp.start_next;
      guard_nxt     = guard_r + 1'b1;
      if (rsp.complete) begin
        phase_nxt = PH_COMPLETE;
      end
      if (rsp.load) begin
        delay_nxt   = dly_sat[DELAY_BITS-1:0];
        running_nxt = 1'b1;
      end
      if (rsp.done) begin
        finish = 1'b1;
      end else if (guard_r == GUARD_W'(CHAIN_LIMIT - 1)) begin
        // runaway chain of zero delays: give up with the timer stopped
        finish      = 1'b1;
        running_nxt = 1'b0;
        delay_nxt   = '0;
      end
      emit = finish;
    end

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_led_nxt    = led_nxt;
      out_phase_nxt  = phase_nxt;
      out_status_nxt = status_nxt;
      out_rej_nxt    = rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      status_r    <= STATUS_OFF;
      phase_r     <= PH_IDLE;
      step_idx_r  <= '0;
      flash_cnt_r <= '0;
      led_r       <= 1'b0;
      delay_r     <= '0;
      running_r   <= 1'b0;
      guard_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      phase_r     <= phase_nxt;
      step_idx_r  <= step_idx_nxt;
      flash_cnt_r <= flash_cnt_nxt;
      led_r       <= led_nxt;
      delay_r     <= delay_nxt;
      running_r   <= running_nxt;
      guard_r     <= guard_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_led_r    <= out_led_nxt;
    out_phase_r  <= out_phase_nxt;
    out_status_r <= out_status_nxt;
    out_rej_r    <= out_rej_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_led_on        = out_led_r;
  assign out_pattern_phase = out_phase_r;
  assign out_sel_status    = out_status_r;
  assign out_rejected      = out_rej_r;

endmodule

[sim/lsps_checker.sv]
// Checker for the LED status pattern sequencer: watches both channels, predicts
// each result and compares it with what the block returns.
// Depends on lsps_pkg for the action and phase codes.
`timescale 1ns / 1ps

module lsps_checker #(
  parameter int STATUS_COUNT = 9,
  parameter int DELAY_BITS   = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_status,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_led_on,
  input  logic [1:0] out_pattern_phase,
  input  logic [3:0] out_sel_status,
  input  logic       out_rejected,
  output int         errors,
  output int         pending
);
  import lsps_pkg::*;

  localparam int unsigned DLY_MAX     = (1 << DELAY_BITS) - 1;
  localparam int unsigned RECHECK_MS  = 1000;
  localparam int          CHAIN_BOUND = 64;

  typedef struct packed {
    logic [11:0] on_ms;
    logic [11:0] off_ms;
    logic        rpt;
    logic [1:0]  flashes;
  } blink_step_t;

  typedef struct packed {
    logic       led_on;
    logic [1:0] phase;
    logic [3:0] status;
    logic       rejected;
  } lamp_view_t;

  // predicted sequencer state
  logic [3:0]            lamp_status;
  phase_t                lamp_phase;
  logic [1:0]            step_idx;
  logic [1:0]            flash_cnt;
  logic                  led_lvl;
  logic [DELAY_BITS-1:0] countdown;
  logic                  timing;

  lamp_view_t views_due[$];

  // blink table: anything not listed holds the LED off
  function automatic blink_step_t blink_step(input logic [3:0] st, input logic [1:0] idx);
    blink_step_t s;
    s = '0;
    case (st)
      4'd0, 4'd2, 4'd4: if (idx == 2'd0) s = {12'd2000, 12'd0, 1'b1, 2'd1};
      4'd1:             if (idx == 2'd0) s = {12'd200, 12'd800, 1'b0, 2'd1};
      4'd5:             if (idx == 2'd0) s = {12'd200, 12'd2800, 1'b0, 2'd1};
      4'd3: begin
        if (idx == 2'd0) s = {12'd200, 12'd200, 1'b1, 2'd2};
        if (idx == 2'd1) s = {12'd0, 12'd600, 1'b1, 2'd1};
        if (idx == 2'd2) s = {12'd200, 12'd200, 1'b0, 2'd2};
      end
      4'd7: begin
        if (idx == 2'd0) s = {12'd100, 12'd100, 1'b1, 2'd3};
        if (idx == 2'd1) s = {12'd0, 12'd2700, 1'b1, 2'd1};
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic int unsigned pattern_len(input logic [3:0] st);
    case (st)
      4'd3:    return 3;
      4'd7:    return 2;
      default: return 1;
    endcase
  endfunction

  // Walks steps until a non-zero delay is loaded, the pattern completes or CHAIN_BOUND steps are spent.
  function automatic void walk_pattern(input bit fresh);
    blink_step_t s;
    blink_step_t head;
    int unsigned d;
    bit          fresh_step;
    fresh_step = fresh;
    head = blink_step(lamp_status, 2'd0);
    for (int g = 0; g < CHAIN_BOUND; g++) begin
      if (fresh_step) begin
        if (step_idx >= pattern_len(lamp_status)) begin
          if (!head.rpt) begin
            step_idx = 2'd0;
          end else begin
            lamp_phase = PH_COMPLETE;
            led_lvl    = 1'b0;
            return;
          end
        end
        flash_cnt  = 2'd0;
        fresh_step = 1'b0;
      end
      s = blink_step(lamp_status, step_idx);
      if (s.flashes != 2'd0 && flash_cnt >= s.flashes) begin
        step_idx   = step_idx + 2'd1;
        fresh_step = 1'b1;
        continue;
      end
      if (s.on_ms == 12'd0 && s.off_ms == 12'd0) begin
        led_lvl = 1'b0;
        d       = RECHECK_MS;
      end else if (!led_lvl) begin
        led_lvl = 1'b1;
        d       = s.on_ms;
      end else begin
        led_lvl   = 1'b0;
        d         = s.off_ms;
        flash_cnt = flash_cnt + 2'd1;
      end
      if (d != 0) begin
        if (d > DLY_MAX) d = DLY_MAX;
        countdown = d[DELAY_BITS-1:0];
        timing    = 1'b1;
        return;
      end
    end
    timing    = 1'b0;
    countdown = '0;
  endfunction

  function automatic void clear_lamp();
    lamp_status = STATUS_OFF;
    lamp_phase  = PH_IDLE;
    step_idx    = 2'd0;
    flash_cnt   = 2'd0;
    led_lvl     = 1'b0;
    countdown   = '0;
    timing      = 1'b0;
  endfunction

  function automatic lamp_view_t next_lamp_view(input logic [1:0] act, input logic [3:0] st);
    logic rej;
    rej = 1'b0;
    case (act)
      ACT_TICK: begin
        if (timing) begin
          if (countdown <= 1) begin
            countdown = '0;
            timing    = 1'b0;
            if (lamp_phase == PH_ACTIVE) walk_pattern(1'b0);
          end else begin
            countdown = countdown - 1'b1;
          end
        end
      end
      ACT_SELECT: begin
        if (st >= STATUS_COUNT) begin
          rej = 1'b1;
        end else begin
          timing      = 1'b0;
          countdown   = '0;
          lamp_status = st;
          lamp_phase  = PH_ACTIVE;
          step_idx    = 2'd0;
          flash_cnt   = 2'd0;
          if (st == STATUS_OFF || st == STATUS_OTA_OK) begin
            led_lvl    = 1'b0;
            lamp_phase = PH_COMPLETE;
          end else begin
            walk_pattern(1'b1);
          end
        end
      end
      ACT_STOP: begin
        timing      = 1'b0;
        countdown   = '0;
        led_lvl     = 1'b0;
        lamp_phase  = PH_IDLE;
        lamp_status = STATUS_OFF;
      end
      default: ;  // unused code leaves everything alone
    endcase
    return {led_lvl, lamp_phase, lamp_status, rej};
  endfunction

  task automatic flag(input string what, input logic [3:0] want, input logic [3:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    lamp_view_t got;
    lamp_view_t want;
    if (!rst_n) begin
      clear_lamp();
      views_due.delete();
      pending <= 0;
    end else begin
      // result first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        got = {out_led_on, out_pattern_phase, out_sel_status, out_rejected};
        if (views_due.size() == 0) begin
          errors++;
          $display("%0t: result transfer, expected none, actual %h", $time, got);
        end else begin
          want = views_due.pop_front();
          if (got.led_on !== want.led_on)
            flag("led_on", 4'(want.led_on), 4'(got.led_on));
          if (got.phase !== want.phase)
            flag("pattern_phase", 4'(want.phase), 4'(got.phase));
          if (got.status !== want.status)
            flag("sel_status", want.status, got.status);
          if (got.rejected !== want.rejected)
            flag("rejected", 4'(want.rejected), 4'(got.rejected));
        end
      end
      if (in_valid && !in_stall) views_due.push_back(next_lamp_view(in_action, in_status));
      pending <= views_due.size();
    end
  end

endmodule

[sim/tb_led_status_pattern_sequencer.sv]
// Testbench top for the LED status pattern sequencer: clock, reset, stimulus and verdict.
// Depends on lsps_pkg, led_status_pattern_sequencer and the lsps_checker module.
`timescale 1ns / 1ps

module tb_led_status_pattern_sequencer;
  import lsps_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_TICK;
  logic [3:0] in_status = 4'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_led_on;
  logic [1:0] out_pattern_phase;
  logic [3:0] out_sel_status;
  logic       out_rejected;
  int         errors;
  int         pending;

  int unsigned sent;
  bit          quiet_tx;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  led_status_pattern_sequencer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_status         (in_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_on        (out_led_on),
    .out_pattern_phase (out_pattern_phase),
    .out_sel_status    (out_sel_status),
    .out_rejected      (out_rejected)
  );

  lsps_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_status         (in_status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_on        (out_led_on),
    .out_pattern_phase (out_pattern_phase),
    .out_sel_status    (out_sel_status),
    .out_rejected      (out_rejected),
    .errors            (errors),
    .pending           (pending)
  );

  // One input transfer; unless quiet_tx is set, each cycle before it may idle at random.
  task automatic send_item(input logic [1:0] act, input logic [3:0] st);
    while (!quiet_tx && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_status <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 4))
      0:       send_item(ACT_STOP, 4'($urandom_range(0, 15)));
      1:       send_item(ACT_SELECT, 4'($urandom_range(9, 15)));
      2:       send_item(ACT_UNUSED, 4'($urandom_range(0, 15)));
      3:       send_item(ACT_SELECT, 4'($urandom_range(0, 15)));
      default: send_item(ACT_TICK, 4'($urandom_range(0, 15)));
    endcase
  endtask

  task automatic tick_run(input int unsigned n, input bit noisy);
    repeat (n) begin
      if (noisy && $urandom_range(0, 99) < 3) noise_item();
      else send_item(ACT_TICK, 4'($urandom_range(0, 15)));
    end
  endtask

  // Select a status and tick past its restart or its first step change.
  task automatic full_pass(input int unsigned which);
    logic [3:0]  st;
    int unsigned span;
    case (which)
      0:       begin st = 4'd1; span = 1000; end
      default: begin st = 4'd7; span = 600; end
    endcase
    send_item(ACT_SELECT, st);
    tick_run(span + $urandom_range(1, 40), 1'b0);
  endtask

  // receiver: random stalls, one long hold-off and one stretch with none
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 400 && cyc < 480) out_stall <= 1'b1;
      else if (cyc >= 1800 && cyc < 2400) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  initial begin
    int unsigned base;
    int unsigned rnd;
    logic [3:0]  st;
    sent     = 0;
    quiet_tx = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stopped timer, unused code, rejects, every status, stops
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_UNUSED, 4'd15);
    send_item(ACT_SELECT, 4'd15);
    send_item(ACT_SELECT, 4'd9);
    for (int s = 0; s <= 8; s++) send_item(ACT_SELECT, s[3:0]);
    send_item(ACT_STOP, 4'd0);
    send_item(ACT_TICK, 4'd15);
    send_item(ACT_SELECT, 4'd7);
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_SELECT, 4'd3);
    send_item(ACT_UNUSED, 4'd0);
    send_item(ACT_STOP, 4'd15);
    send_item(ACT_STOP, 4'd0);
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_SELECT, 4'd6);
    send_item(ACT_TICK, 4'd0);

    // slow blink through its restart, sender never idling
    base     = sent;
    quiet_tx = 1'b1;
    full_pass(0);
    quiet_tx = 1'b0;
    // hold the sender until every result is back
    wait_drained();
    // fast burst into its zero on-time step
    full_pass(1);

    // random: select then tick episodes and noise
    rnd = sent - base;
    while (rnd < 1880) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 5))
          0:       st = 4'd1;
          1:       st = 4'd3;
          2:       st = 4'd7;
          default: st = 4'($urandom_range(0, 8));
        endcase
        send_item(ACT_SELECT, st);
        tick_run($urandom_range(0, 60), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) noise_item();
      end
      rnd = sent - base;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: transfers stopped");
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
src/lsps_pkg.sv
src/lsps_step_unit.sv
src/led_status_pattern_sequencer.sv
sim/lsps_checker.sv
sim/tb_led_status_pattern_sequencer.sv
